/* design/jda_pkg.sv */
// Shared types and codes for the jukebox drive allocator.
package jda_pkg;

  // Field widths fixed by the interface
  localparam int SIDE_W    = 7;
  localparam int NOW_W     = 32;
  localparam int STATUS_W  = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 64;

  // Operation codes
  localparam logic OP_ACCESS = 1'b0;
  localparam logic OP_SWEEP  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_HIT      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_LOADED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RETRY    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_SIDE = 3'd4;
  localparam logic [STATUS_W-1:0] ST_SWEEP    = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SHELF_COUNT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_SIDED   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHELF_OCCUPIED = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_COUNT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_PRESENT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT   = 3'd6;

  typedef struct packed {
    logic              operation;
    logic [SIDE_W-1:0] side;
    logic [NOW_W-1:0]  now;
  } jda_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [2:0]          drive;
    logic                evicted;
    logic [SIDE_W-1:0]   evicted_side;
    logic [7:0]          unloaded_mask;
  } jda_result_t;

  typedef struct packed {
    logic [6:0]  shelf_count;
    logic        double_sided;
    logic [63:0] shelf_occupied;
    logic [3:0]  drive_count;
    logic [7:0]  drive_present;
    logic [31:0] hysteresis;
    logic [31:0] idle_timeout;
  } jda_cfg_t;

  // Write command to the drive table
  typedef struct packed {
    logic clr;    // unload the drive
    logic load;   // load a side, stamp spin-up and access time
    logic touch;  // refresh access time only
  } jda_tbl_cmd_t;

endpackage

/* design/jukebox_drive_allocator.sv */
// Jukebox drive allocator top level: configuration registers and unit wiring.
// Flow: after an item is accepted the sequencer scans the drive entries through the
// shared age unit, then registers the result; a hit ends the scan at that drive and
// a bad side skips the scan. The next item is taken while the previous result waits
// in the output register; a result not yet taken holds the finish state. Reset:
// configuration returns to its defaults and all drives read as empty.
module jukebox_drive_allocator import jda_pkg::*; #(
  parameter int MAX_DRIVES  = 8,
  parameter int MAX_SHELVES = 64,
  parameter int TIME_BITS   = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  jda_item_t            item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output jda_result_t          result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int DW = (MAX_DRIVES > 1) ? $clog2(MAX_DRIVES) : 1;
  localparam int CW = (TIME_BITS > 32) ? TIME_BITS : 32;

  jda_cfg_t             cfg;
  logic [DW-1:0]        rd_idx;
  logic                 rd_loaded;
  logic [SIDE_W-1:0]    rd_side;
  logic [TIME_BITS-1:0] rd_spin;
  logic [TIME_BITS-1:0] rd_acc;
  logic [DW-1:0]        wr_idx;
  jda_tbl_cmd_t         wr_cmd;
  logic [SIDE_W-1:0]    wr_side;
  logic [TIME_BITS-1:0] wr_time;
  logic [TIME_BITS-1:0] au_now;
  logic [TIME_BITS-1:0] au_stamp;
  logic [CW-1:0]        au_thr;
  logic [TIME_BITS-1:0] au_age;
  logic                 au_gt;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.shelf_count    <= 7'd50;
      cfg.double_sided   <= 1'b1;
      cfg.shelf_occupied <= '0;
      cfg.drive_count    <= 4'd2;
      cfg.drive_present  <= '0;
      cfg.hysteresis     <= 32'd10;
      cfg.idle_timeout   <= 32'd600;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SHELF_COUNT:    cfg.shelf_count    <= cfg_data[6:0];
        CFG_DOUBLE_SIDED:   cfg.double_sided   <= cfg_data[0];
        CFG_SHELF_OCCUPIED: cfg.shelf_occupied <= cfg_data;
        CFG_DRIVE_COUNT:    cfg.drive_count    <= cfg_data[3:0];
        CFG_DRIVE_PRESENT:  cfg.drive_present  <= cfg_data[7:0];
        CFG_HYSTERESIS:     cfg.hysteresis     <= cfg_data[31:0];
        CFG_IDLE_TIMEOUT:   cfg.idle_timeout   <= cfg_data[31:0];
        default: begin
        end
      endcase
    end
  end

  jda_age_unit #(
    .TIME_BITS(TIME_BITS)
  ) u_age (
    .now   (au_now),
    .stamp (au_stamp),
    .thr   (au_thr),
    .age   (au_age),
    .gt    (au_gt)
  );

  jda_drive_table #(
    .MAX_DRIVES(MAX_DRIVES),
    .TIME_BITS (TIME_BITS)
  ) u_table (
    .clk       (clk),
    .rst       (rst),
    .rd_idx    (rd_idx),
    .rd_loaded (rd_loaded),
    .rd_side   (rd_side),
    .rd_spin   (rd_spin),
    .rd_acc    (rd_acc),
    .wr_idx    (wr_idx),
    .wr_cmd    (wr_cmd),
    .wr_side   (wr_side),
    .wr_time   (wr_time)
  );

  jda_seq #(
    .MAX_DRIVES (MAX_DRIVES),
    .MAX_SHELVES(MAX_SHELVES),
    .TIME_BITS  (TIME_BITS)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .rd_idx       (rd_idx),
    .rd_loaded    (rd_loaded),
    .rd_side      (rd_side),
    .rd_spin      (rd_spin),
    .rd_acc       (rd_acc),
    .wr_idx       (wr_idx),
    .wr_cmd       (wr_cmd),
    .wr_side      (wr_side),
    .wr_time      (wr_time),
    .au_now       (au_now),
    .au_stamp     (au_stamp),
    .au_thr       (au_thr),
    .au_age       (au_age),
    .au_gt        (au_gt)
  );

  // Busy in the cycle after taking an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("item taken while the previous one is still in work");

  // Eviction is reported only with a fresh load
  a_evict_only_on_load: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.evicted |-> result.status == ST_LOADED)
    else $error("eviction reported without a load");

  // Unload mask belongs to the sweep result alone
  a_mask_only_on_sweep: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.unloaded_mask != 8'd0) |-> result.status == ST_SWEEP)
    else $error("unload mask set outside a sweep");

  // Drive table changes only while an item is in work, never while idle
  a_table_idle: assert property (@(posedge clk) disable iff (rst)
    item_ready |-> !(wr_cmd.clr || wr_cmd.load || wr_cmd.touch))
    else $error("drive table written while idle");

endmodule

/* design/jda_age_unit.sv */
// Shared age unit: wrapped time difference and strict compare against a threshold.
module jda_age_unit import jda_pkg::*; #(
  parameter int TIME_BITS = 32
) (
  input  logic [TIME_BITS-1:0]                         now,
  input  logic [TIME_BITS-1:0]                         stamp,
  input  logic [((TIME_BITS > 32) ? TIME_BITS : 32)-1:0] thr,
  output logic [TIME_BITS-1:0]                         age,
  output logic                                         gt
);

  localparam int CW = (TIME_BITS > 32) ? TIME_BITS : 32;

  // Subtract wraps modulo the time width
  assign age = now - stamp;
  assign gt  = CW'(age) > thr;

endmodule

/* design/jda_drive_table.sv */
// Per-drive state: loaded flag, loaded side, spin-up and access time stamps.
module jda_drive_table import jda_pkg::*; #(
  parameter int MAX_DRIVES = 8,
  parameter int TIME_BITS  = 32
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  logic [((MAX_DRIVES > 1) ? $clog2(MAX_DRIVES) : 1)-1:0] rd_idx,
  output logic                                             rd_loaded,
  output logic [SIDE_W-1:0]                                rd_side,
  output logic [TIME_BITS-1:0]                             rd_spin,
  output logic [TIME_BITS-1:0]                             rd_acc,
  input  logic [((MAX_DRIVES > 1) ? $clog2(MAX_DRIVES) : 1)-1:0] wr_idx,
  input  jda_tbl_cmd_t                                     wr_cmd,
  input  logic [SIDE_W-1:0]                                wr_side,
  input  logic [TIME_BITS-1:0]                             wr_time
);

  logic [MAX_DRIVES-1:0] loaded;
  logic [SIDE_W-1:0]     side_mem [MAX_DRIVES];
  logic [TIME_BITS-1:0]  spin_mem [MAX_DRIVES];
  logic [TIME_BITS-1:0]  acc_mem  [MAX_DRIVES];

  // Read the entry under the scan pointer
  assign rd_loaded = loaded[rd_idx];
  assign rd_side   = side_mem[rd_idx];
  assign rd_spin   = spin_mem[rd_idx];
  assign rd_acc    = acc_mem[rd_idx];

  // Loaded flags clear at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= '0;
    end else if (wr_cmd.clr) begin
      loaded[wr_idx] <= 1'b0;
    end else if (wr_cmd.load) begin
      loaded[wr_idx] <= 1'b1;
    end
  end

  // Side and time stamps hold no reset value
  always_ff @(posedge clk) begin
    if (wr_cmd.load) begin
      side_mem[wr_idx] <= wr_side;
      spin_mem[wr_idx] <= wr_time;
    end
    if (wr_cmd.load || wr_cmd.touch) begin
      acc_mem[wr_idx] <= wr_time;
    end
  end

endmodule

/* design/jda_seq.sv */
// Sequencer: scans drives one per cycle, picks/unloads, registers the result.
module jda_seq import jda_pkg::*; #(
  parameter int MAX_DRIVES  = 8,
  parameter int MAX_SHELVES = 64,
  parameter int TIME_BITS   = 32
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  jda_cfg_t                                         cfg,
  input  logic                                             item_valid,
  output logic                                             item_ready,
  input  jda_item_t                                        item,
  output logic                                             result_valid,
  input  logic                                             result_ready,
  output jda_result_t                                      result,
  output logic [((MAX_DRIVES > 1) ? $clog2(MAX_DRIVES) : 1)-1:0] rd_idx,
  input  logic                                             rd_loaded,
  input  logic [SIDE_W-1:0]                                rd_side,
  input  logic [TIME_BITS-1:0]                             rd_spin,
  input  logic [TIME_BITS-1:0]                             rd_acc,
  output logic [((MAX_DRIVES > 1) ? $clog2(MAX_DRIVES) : 1)-1:0] wr_idx,
  output jda_tbl_cmd_t                                     wr_cmd,
  output logic [SIDE_W-1:0]                                wr_side,
  output logic [TIME_BITS-1:0]                             wr_time,
  output logic [TIME_BITS-1:0]                             au_now,
  output logic [TIME_BITS-1:0]                             au_stamp,
  output logic [((TIME_BITS > 32) ? TIME_BITS : 32)-1:0]   au_thr,
  input  logic [TIME_BITS-1:0]                             au_age,
  input  logic                                             au_gt
);

  localparam int DW = (MAX_DRIVES > 1) ? $clog2(MAX_DRIVES) : 1;
  localparam int TW = TIME_BITS;
  localparam int CW = (TIME_BITS > 32) ? TIME_BITS : 32;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } jda_state_t;

  jda_state_t        state;
  logic              op;
  logic [SIDE_W-1:0] side_q;
  logic [TW-1:0]     now_q;
  logic [SIDE_W-1:0] shelf_q;
  logic              bad;
  logic              empty;
  logic [DW-1:0]     idx;
  logic              hit;
  logic [DW-1:0]     hit_idx;
  logic              alloc_done;
  logic              cvalid;
  logic [DW-1:0]     cidx;
  logic              blocked;
  logic [CW-1:0]     best;
  logic              ev;
  logic [SIDE_W-1:0] ev_side;
  logic [7:0]        mask;
  jda_result_t       result_next;

  logic [SIDE_W-1:0] sc;
  logic [7:0]        ns;
  logic [4:0]        nd;
  logic [SIDE_W-1:0] in_shelf;
  logic              in_bad;
  logic [SIDE_W-1:0] lshelf;
  logic              same;
  logic              hit_now;
  logic              active;
  logic              last;
  logic [4:0]        idx_w;
  logic [4:0]        hit_w;
  logic [4:0]        cidx_w;
  logic              out_free;

  // Clamp configured counts to the built sizes
  assign sc = (cfg.shelf_count < SIDE_W'(MAX_SHELVES)) ? cfg.shelf_count
                                                       : SIDE_W'(MAX_SHELVES);
  assign ns = cfg.double_sided ? {sc, 1'b0} : {1'b0, sc};
  assign nd = ({1'b0, cfg.drive_count} < 5'(MAX_DRIVES)) ? {1'b0, cfg.drive_count}
                                                         : 5'(MAX_DRIVES);

  // Classify the incoming side
  assign in_bad   = {1'b0, item.side} >= ns;
  assign in_shelf = (item.side < sc) ? item.side : item.side - sc;

  // Per-drive decode under the scan pointer
  assign idx_w   = 5'(idx);
  assign hit_w   = 5'(hit_idx);
  assign cidx_w  = 5'(cidx);
  assign last    = idx == DW'(MAX_DRIVES - 1);
  assign lshelf  = (rd_side < sc) ? rd_side : rd_side - sc;
  assign same    = lshelf == shelf_q;
  assign hit_now = (op == OP_ACCESS) && rd_loaded && (rd_side == side_q);
  assign active  = (op == OP_ACCESS) && !alloc_done && (idx_w < nd);
  assign out_free = !result_valid || result_ready;

  // Feed the shared age unit
  assign au_now   = now_q;
  assign au_stamp = (op == OP_SWEEP) ? rd_acc : rd_spin;
  assign au_thr   = (op == OP_SWEEP) ? CW'(cfg.idle_timeout)
                  : (same ? CW'(cfg.hysteresis) : best);

  assign rd_idx     = idx;
  assign item_ready = state == S_IDLE;

  // Drive table writes
  always_comb begin
    wr_cmd  = '0;
    wr_idx  = idx;
    wr_side = side_q;
    wr_time = now_q;
    if (state == S_SCAN && op == OP_SWEEP && rd_loaded && au_gt) begin
      wr_cmd.clr = 1'b1;
    end else if (state == S_FIN && out_free && op == OP_ACCESS && !bad) begin
      if (hit) begin
        wr_cmd.touch = 1'b1;
        wr_idx       = hit_idx;
      end else if (!empty && cvalid) begin
        wr_cmd.load = 1'b1;
        wr_idx      = cidx;
      end
    end
  end

  // Build the result
  always_comb begin
    result_next = '0;
    if (op == OP_SWEEP) begin
      result_next.status        = ST_SWEEP;
      result_next.unloaded_mask = mask;
    end else if (bad) begin
      result_next.status = ST_BAD_SIDE;
    end else if (hit) begin
      result_next.status = ST_HIT;
      result_next.drive  = hit_w[2:0];
    end else if (empty) begin
      result_next.status = ST_EMPTY;
    end else if (!cvalid) begin
      result_next.status = ST_RETRY;
    end else begin
      result_next.status       = ST_LOADED;
      result_next.drive        = cidx_w[2:0];
      result_next.evicted      = ev;
      result_next.evicted_side = ev ? ev_side : '0;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      // Drop the result once taken, unless a new one replaces it now
      if (result_valid && result_ready && state != S_FIN) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            op         <= item.operation;
            side_q     <= item.side;
            now_q      <= TW'(item.now);
            shelf_q    <= in_shelf;
            bad        <= in_bad && (item.operation == OP_ACCESS);
            empty      <= !cfg.shelf_occupied[in_shelf[5:0]];
            idx        <= '0;
            hit        <= 1'b0;
            alloc_done <= 1'b0;
            cvalid     <= 1'b0;
            blocked    <= 1'b0;
            best       <= CW'(cfg.hysteresis);
            ev         <= 1'b0;
            mask       <= '0;
            state      <= (in_bad && item.operation == OP_ACCESS) ? S_FIN : S_SCAN;
          end
        end
        S_SCAN: begin
          idx <= idx + 1'b1;
          if (op == OP_SWEEP) begin
            // Unload idle drives, report the low eight
            if (rd_loaded && au_gt && idx_w < 5'd8) begin
              mask[idx_w[2:0]] <= 1'b1;
            end
            if (last) begin
              state <= S_FIN;
            end
          end else if (hit_now) begin
            hit     <= 1'b1;
            hit_idx <= idx;
            state   <= S_FIN;
          end else begin
            // Drive selection by priority
            if (active) begin
              if (!rd_loaded) begin
                if (idx_w < 5'd8 && cfg.drive_present[idx_w[2:0]]) begin
                  cvalid  <= 1'b1;
                  cidx    <= idx;
                  blocked <= 1'b1;
                  ev      <= 1'b0;
                end
              end else if (same) begin
                cvalid     <= au_gt;
                cidx       <= idx;
                ev         <= 1'b1;
                ev_side    <= rd_side;
                alloc_done <= 1'b1;
              end else if (!blocked && au_gt) begin
                cvalid  <= 1'b1;
                cidx    <= idx;
                best    <= CW'(au_age);
                ev      <= 1'b1;
                ev_side <= rd_side;
              end
            end
            if (last) begin
              state <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            result_valid <= 1'b1;
            result       <= result_next;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
